@@ hdl/dttfp_pkg.sv @@
// Package for the decimal text to fixed point block: character codes, item
// classes, parser phases, limits and the fraction weight table.
// No dependencies; every other file imports it.
`default_nettype none

package dttfp_pkg;

    localparam int FRAC_BITS       = 32;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam int VALUE_W  = 64;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int FPOS_W   = 4;
    localparam int WEIGHT_W = FRAC_BITS;
    localparam int PROD_W   = WEIGHT_W + DIGIT_W;
    localparam int INT_SUM_W = VALUE_W + 4;
    localparam int FRAC_SUM_W = VALUE_W + 1;
    localparam int WEIGHT_ENTRIES = 1 << FPOS_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [VALUE_W-1:0] POS_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] NEG_LIMIT = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic [FPOS_W-1:0] FPOS_MAX = FPOS_W'(MAX_FRAC_DIGITS);

    typedef enum logic [2:0] {
        K_SPACE,
        K_MINUS,
        K_DIGIT,
        K_POINT,
        K_NUL,
        K_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    typedef struct packed {
        t_kind               kind;
        logic [DIGIT_W-1:0]  digit;
    } t_cmd;

    typedef logic [WEIGHT_ENTRIES-1:0][WEIGHT_W-1:0] t_weight_table;

    // entry k holds floor(2^FRAC_BITS / 10^k) for k >= 1; entry 0 is never read
    function automatic t_weight_table weight_table();
        t_weight_table  tbl;
        logic [63:0]    w;
        w = 64'd1 << FRAC_BITS;
        for (int k = 0; k < WEIGHT_ENTRIES; k++) begin
            tbl[k] = w[WEIGHT_W-1:0];
            w = w / 10;
        end
        return tbl;
    endfunction

    localparam t_weight_table WEIGHT_TABLE = weight_table();

endpackage

`default_nettype wire

@@ hdl/dttfp_front.sv @@
// Front end: classifies each incoming character into an item class and
// digit value. Depends on dttfp_pkg.
`default_nettype none

module dttfp_front
    import dttfp_pkg::*;
(
    input  wire logic [CHAR_W-1:0] i_char_code,
    output t_cmd                   o_cmd
);

    logic [DIGIT_W-1:0] w_digit_off;

    assign w_digit_off = DIGIT_W'(i_char_code - CH_ZERO);

    always_comb begin
        o_cmd.digit = '0;
        if (i_char_code == CH_NUL) begin
            o_cmd.kind = K_NUL;
        end else if (i_char_code == CH_SPACE || i_char_code == CH_TAB) begin
            o_cmd.kind = K_SPACE;
        end else if (i_char_code == CH_MINUS) begin
            o_cmd.kind = K_MINUS;
        end else if (i_char_code == CH_POINT) begin
            o_cmd.kind = K_POINT;
        end else if (i_char_code >= CH_ZERO && i_char_code <= CH_NINE) begin
            o_cmd.kind  = K_DIGIT;
            o_cmd.digit = w_digit_off;
        end else begin
            o_cmd.kind = K_OTHER;
        end
    end

endmodule

`default_nettype wire

@@ hdl/dttfp_queue.sv @@
// Short item queue between front and back ends, register based.
// Depends on dttfp_pkg.
`default_nettype none

module dttfp_queue
    import dttfp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_nonempty,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                w_push, w_pop;

    assign o_full     = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_cmd      = r_mem[r_rd_ptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/dttfp_back.sv @@
// Back end: parser state machine, integer and fraction accumulation with
// saturation, and the registered result stage. Depends on dttfp_pkg.
`default_nettype none

module dttfp_back
    import dttfp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cmd_valid,
    input  wire t_cmd                 i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_saturated
);

    t_phase              r_phase, n_phase;
    logic [VALUE_W-1:0]  r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [FPOS_W-1:0]   r_fpos, n_fpos;
    logic                r_ovf, n_ovf;

    logic                r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic                r_sat, n_sat;

    logic                  w_out_free;
    logic                  w_is_nul;
    logic [VALUE_W-1:0]    w_lim;
    logic [VALUE_W-1:0]    w_dd;
    logic [INT_SUM_W-1:0]  w_int_sum;
    logic [FPOS_W-1:0]     w_fpos_inc;
    logic [WEIGHT_W-1:0]   w_weight;
    logic [PROD_W-1:0]     w_prod;
    logic [FRAC_SUM_W-1:0] w_frac_sum;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_is_nul   = (i_cmd.kind == K_NUL);
    assign o_cmd_pop  = i_cmd_valid && (!w_is_nul || w_out_free);

    assign w_lim      = r_neg ? NEG_LIMIT : POS_LIMIT;
    assign w_dd       = VALUE_W'(i_cmd.digit) << FRAC_BITS;
    assign w_int_sum  = {r_mag, 3'b000} + {2'b00, r_mag, 1'b0}
                      + {4'b0000, w_dd};
    assign w_fpos_inc = r_fpos + 1'b1;
    assign w_weight   = WEIGHT_TABLE[w_fpos_inc];
    assign w_prod     = i_cmd.digit * w_weight;
    assign w_frac_sum = {1'b0, r_mag} + FRAC_SUM_W'(w_prod);

    always_comb begin
        n_phase     = r_phase;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_fpos      = r_fpos;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_stall;
        n_value     = r_value;
        n_sat       = r_sat;
        if (o_cmd_pop) begin
            case (i_cmd.kind)
                K_NUL: begin
                    n_out_valid = 1'b1;
                    n_sat       = r_ovf;
                    if (r_ovf) begin
                        n_value = w_lim;
                    end else begin
                        n_value = r_neg ? VALUE_W'(0) - r_mag : r_mag;
                    end
                    n_phase = PH_LEAD;
                    n_mag   = '0;
                    n_neg   = 1'b0;
                    n_fpos  = '0;
                    n_ovf   = 1'b0;
                end
                K_DIGIT: begin
                    case (r_phase)
                        PH_LEAD, PH_INT: begin
                            n_phase = PH_INT;
                            if (!r_ovf) begin
                                if (w_int_sum > {4'b0000, w_lim}) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_mag = w_int_sum[VALUE_W-1:0];
                                end
                            end
                        end
                        PH_FRAC: begin
                            if (!r_ovf && r_fpos < FPOS_MAX) begin
                                n_fpos = w_fpos_inc;
                                if (w_frac_sum > {1'b0, w_lim}) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_mag = w_frac_sum[VALUE_W-1:0];
                                end
                            end
                        end
                        default: n_phase = PH_DONE;
                    endcase
                end
                K_SPACE: begin
                    if (r_phase != PH_LEAD) begin
                        n_phase = PH_DONE;
                    end
                end
                K_MINUS: begin
                    if (r_phase == PH_LEAD) begin
                        n_neg   = 1'b1;
                        n_phase = PH_INT;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                K_POINT: begin
                    if (r_phase == PH_LEAD || r_phase == PH_INT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: n_phase = PH_DONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_fpos      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_mag       <= n_mag;
            r_neg       <= n_neg;
            r_fpos      <= n_fpos;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_sat   <= n_sat;
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;

`ifndef SYNTH
    a_sat_clamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (r_value == POS_LIMIT || r_value == NEG_LIMIT))
        else $error("saturated result not clamped");

    a_nul_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && w_is_nul) |=> (r_phase == PH_LEAD && r_mag == '0 && !r_ovf
            && !r_neg && r_fpos == '0 && o_valid))
        else $error("terminator did not clear parser state");

    a_fpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fpos <= FPOS_MAX)
        else $error("fraction position past limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_value)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ hdl/decimal_text_to_fixed_point.sv @@
// Top level of the decimal text to fixed point parser: front classifier,
// item queue and back end. Depends on dttfp_pkg, dttfp_front, dttfp_queue,
// dttfp_back.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+------------------------------
//   input   | i_valid | o_stall | i_char_code[7:0]
//   output  | o_valid | i_stall | o_value[63:0], o_saturated
//
// One character per cycle sustained while o_stall is low; the back end state
// update (one multiply-by-ten add and limit compare) is combinational logic
// ahead of the state registers. o_valid rises once its NUL has passed through
// the queue and then the result register.
// Reset is synchronous and active low and clears parser, queue and result valid.
// o_stall rises only when the two-entry queue is full, which happens while a
// result waits under i_stall, a further NUL waits at the queue head and one
// more item is queued behind it.
`default_nettype none

module decimal_text_to_fixed_point
    import dttfp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [CHAR_W-1:0]    i_char_code,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_saturated
);

    t_cmd w_front_cmd;
    t_cmd w_queue_cmd;
    logic w_full;
    logic w_nonempty;
    logic w_pop;

    dttfp_front u_front (
        .i_char_code (i_char_code),
        .o_cmd       (w_front_cmd)
    );

    dttfp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid),
        .i_cmd      (w_front_cmd),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .i_pop      (w_pop),
        .o_cmd      (w_queue_cmd)
    );

    dttfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_nonempty),
        .i_cmd       (w_queue_cmd),
        .o_cmd_pop   (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value     (o_value),
        .o_saturated (o_saturated)
    );

    assign o_stall = w_full;

endmodule

`default_nettype wire
